/* hdl/rmie_pkg.sv */
// shared types, codes and helper functions of the register and memory instruction executor
package rmie_pkg;

   // default sizes handed to the top level parameters
   localparam int DEF_MEM_ADDR_BITS = 12;
   localparam int DEF_NUM_REGS = 6;

   // action codes
   localparam logic [3:0] ACT_NONE  = 4'd0;
   localparam logic [3:0] ACT_STORE = 4'd1;
   localparam logic [3:0] ACT_ADD   = 4'd2;
   localparam logic [3:0] ACT_SUB   = 4'd3;
   localparam logic [3:0] ACT_JEQ   = 4'd4;
   localparam logic [3:0] ACT_JGT   = 4'd5;
   localparam logic [3:0] ACT_CMP   = 4'd6;
   localparam logic [3:0] ACT_NOT   = 4'd7;
   localparam logic [3:0] ACT_AND   = 4'd8;
   localparam logic [3:0] ACT_OR    = 4'd9;
   localparam logic [3:0] ACT_SHL   = 4'd10;
   localparam logic [3:0] ACT_SHR   = 4'd11;

   // addressing mode codes
   localparam logic [2:0] MODE_RR = 3'd0;
   localparam logic [2:0] MODE_RI = 3'd1;
   localparam logic [2:0] MODE_RM = 3'd2;
   localparam logic [2:0] MODE_MR = 3'd3;
   localparam logic [2:0] MODE_MI = 3'd4;
   localparam logic [2:0] MODE_R  = 3'd5;
   localparam logic [2:0] MODE_M  = 3'd6;

   // register code fields
   localparam int CODE_LOW_BIT  = 15;
   localparam int CODE_HIGH_BIT = 14;

   typedef struct packed {
      logic [3:0]  action;
      logic [2:0]  addressing_mode;
      logic [15:0] first_operand;
      logic [15:0] second_operand;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        jump_taken;
      logic [15:0] program_pointer;
      logic        equal_flag;
      logic        greater_flag;
   } rsp_type;

   // actions that run through the two-operand alu
   function automatic logic is_alu_act(input logic [3:0] act);
      logic r;
      case (act)
         ACT_STORE, ACT_ADD, ACT_SUB, ACT_AND, ACT_OR, ACT_SHL, ACT_SHR: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // register code names a byte view
   function automatic logic is_byte_code(input logic [15:0] code);
      return code[CODE_LOW_BIT] | code[CODE_HIGH_BIT];
   endfunction

   // value seen through a register code
   function automatic logic [15:0] reg_view(input logic [15:0] code, input logic [15:0] raw,
                                            input logic in_range);
      logic [15:0] v;
      if (!in_range) begin
         v = 16'h0000;
      end else if (code[CODE_LOW_BIT]) begin
         v = {8'h00, raw[7:0]};
      end else if (code[CODE_HIGH_BIT]) begin
         v = {8'h00, raw[15:8]};
      end else begin
         v = raw;
      end
      return v;
   endfunction

   // new register contents, byte views keep the other byte
   function automatic logic [15:0] reg_merge(input logic [15:0] code, input logic [15:0] old,
                                             input logic [15:0] val);
      logic [15:0] v;
      if (code[CODE_LOW_BIT]) begin
         v = {old[15:8], val[7:0]};
      end else if (code[CODE_HIGH_BIT]) begin
         v = {val[7:0], old[7:0]};
      end else begin
         v = val;
      end
      return v;
   endfunction

   // two-operand alu
   function automatic logic [15:0] alu(input logic [3:0] act, input logic [15:0] a,
                                       input logic [15:0] b);
      logic [15:0] r;
      case (act)
         ACT_STORE: r = b;
         ACT_ADD:   r = a + b;
         ACT_SUB:   r = a - b;
         ACT_AND:   r = a & b;
         ACT_OR:    r = a | b;
         ACT_SHL:   r = (b[15:4] != 12'h000) ? 16'h0000 : (a << b[3:0]);
         ACT_SHR:   r = (b[15:4] != 12'h000) ? 16'h0000 : (a >> b[3:0]);
         default:   r = 16'h0000;
      endcase
      return r;
   endfunction

endpackage

/* hdl/register_memory_instruction_executor_top.sv */
// register and memory instruction executor, single module
//
// Executes one instruction per req_ transaction on a machine with NUM_REGS
// 16-bit registers, a byte memory of 2**MEM_ADDR_BITS entries, equal and
// greater flags and a 16-bit instruction pointer. Every request gives
// exactly one rsp_ transaction with the accept bit, the jump bit, the
// pointer and both flags after the instruction.
// A one-entry request buffer takes the next instruction while the current
// one executes, and an output register holds the response, so the two
// sides stall independently. An instruction passes the issue and execute
// steps of the sequencer, with a fetch step between them when it reads a
// big-endian memory word and a write step after execute when it writes
// one back; the single-port byte memory sets this.
// While the response register is full and not taken, the sequencer holds
// in its execute step and nothing is committed.
// After reset a clearing pass zeroes the data memory and the register
// file, one address per cycle; req_ready stays low until it ends.
module register_memory_instruction_executor_top #(
   parameter int MEM_ADDR_BITS = rmie_pkg::DEF_MEM_ADDR_BITS,
   parameter int NUM_REGS = rmie_pkg::DEF_NUM_REGS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmie_pkg::rsp_type rsp_data
);
   import rmie_pkg::*;

   localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
   localparam int RIDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam logic [4:0] NREG = 5'(NUM_REGS);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_ISSUE  = 5'b00010,
      ST_FETCH2 = 5'b00100,
      ST_EXEC   = 5'b01000,
      ST_WRITE2 = 5'b10000
   } state_type;

   // storage
   logic [7:0]  data_mem [MEM_DEPTH];
   logic [15:0] reg_mem [NUM_REGS];

   state_type              state_ff, state_in;
   logic [MEM_ADDR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                   buf_valid_ff, buf_valid_in;
   req_type                buf_ff;
   req_type                cur_ff;
   logic [15:0]            rda_ff, rdb_ff;
   logic                   ina_ff, inb_ff;
   logic [7:0]             mem_rd_ff;
   logic [7:0]             byte_hi_ff;
   logic [7:0]             wr2_ff;
   logic [15:0]            ip_ff;
   logic                   eq_ff, gt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;

   logic                   req_fire, take, exec_fire;
   logic                   buf_ina, buf_inb, buf_word_rd;
   logic [RIDX_BITS-1:0]   rd_addr_a, rd_addr_b;

   // memory port controls
   logic                   mem_re, mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic [7:0]             mem_wdata;
   logic                   rf_we;
   logic [RIDX_BITS-1:0]   rf_waddr;
   logic [15:0]            rf_wdata;

   // execute step results
   logic                   ex_acc, ex_jt, ex_reg_we, ex_mem_we, ex_word_wr;
   logic [15:0]            ex_reg_wdata, ex_res, ex_b, ex_target;
   logic [7:0]             ex_mem_wdata, ex_wr2;
   logic [15:0]            ip_in;
   logic                   eq_in, gt_in;
   logic [15:0]            va, vb, mbyte, mword;
   logic [MEM_ADDR_BITS-1:0] cur_addr, cur_addr_next;

   // handshakes
   assign req_ready = (state_ff != ST_CLEAR) && (!buf_valid_ff || (state_ff == ST_ISSUE));
   assign req_fire  = req_valid && req_ready;
   assign take      = (state_ff == ST_ISSUE) && buf_valid_ff;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // register read addressing from the buffered request
   assign buf_ina = {1'b0, buf_ff.first_operand[3:0]} < NREG;
   assign buf_inb = {1'b0, buf_ff.second_operand[3:0]} < NREG;
   assign rd_addr_a = buf_ina ? buf_ff.first_operand[RIDX_BITS-1:0] : '0;
   assign rd_addr_b = buf_inb ? buf_ff.second_operand[RIDX_BITS-1:0] : '0;

   // big-endian word read needed
   assign buf_word_rd =
      (is_alu_act(buf_ff.action) && (buf_ff.addressing_mode == MODE_MR) &&
       !is_byte_code(buf_ff.second_operand)) ||
      (((buf_ff.action == ACT_JEQ) || (buf_ff.action == ACT_JGT)) &&
       (buf_ff.addressing_mode == MODE_M));

   assign cur_addr      = cur_ff.first_operand[MEM_ADDR_BITS-1:0];
   assign cur_addr_next = cur_addr + MEM_ADDR_BITS'(1);

   // execute step
   always_comb begin
      va    = reg_view(cur_ff.first_operand, rda_ff, ina_ff);
      vb    = reg_view(cur_ff.second_operand, rdb_ff, inb_ff);
      mbyte = {8'h00, mem_rd_ff};
      mword = {byte_hi_ff, mem_rd_ff};
      ex_acc       = 1'b0;
      ex_jt        = 1'b0;
      ex_reg_we    = 1'b0;
      ex_mem_we    = 1'b0;
      ex_word_wr   = 1'b0;
      ex_reg_wdata = 16'h0000;
      ex_res       = 16'h0000;
      ex_b         = 16'h0000;
      ex_target    = 16'h0000;
      ex_mem_wdata = 8'h00;
      ex_wr2       = 8'h00;
      ip_in        = ip_ff;
      eq_in        = eq_ff;
      gt_in        = gt_ff;
      case (cur_ff.action)
         ACT_NONE: begin
            ex_acc = 1'b1;
         end
         ACT_STORE, ACT_ADD, ACT_SUB, ACT_AND, ACT_OR, ACT_SHL, ACT_SHR: begin
            case (cur_ff.addressing_mode)
               MODE_RR, MODE_RI, MODE_RM: begin
                  ex_acc = 1'b1;
                  if (cur_ff.addressing_mode == MODE_RR) begin
                     ex_b = vb;
                  end else if (cur_ff.addressing_mode == MODE_RI) begin
                     ex_b = cur_ff.second_operand;
                  end else begin
                     ex_b = mbyte;
                  end
                  ex_res       = alu(cur_ff.action, va, ex_b);
                  ex_reg_we    = 1'b1;
                  ex_reg_wdata = reg_merge(cur_ff.first_operand, rda_ff, ex_res);
               end
               MODE_MR: begin
                  ex_acc    = 1'b1;
                  ex_mem_we = 1'b1;
                  if (is_byte_code(cur_ff.second_operand)) begin
                     ex_res       = alu(cur_ff.action, mbyte, vb);
                     ex_mem_wdata = ex_res[7:0];
                  end else begin
                     ex_res       = alu(cur_ff.action, mword, vb);
                     ex_mem_wdata = ex_res[15:8];
                     ex_wr2       = ex_res[7:0];
                     ex_word_wr   = 1'b1;
                  end
               end
               MODE_MI: begin
                  ex_acc       = 1'b1;
                  ex_mem_we    = 1'b1;
                  ex_res       = alu(cur_ff.action, mbyte, cur_ff.second_operand);
                  ex_mem_wdata = ex_res[7:0];
               end
               default: begin
                  ex_acc = 1'b0;
               end
            endcase
         end
         ACT_JEQ, ACT_JGT: begin
            if ((cur_ff.addressing_mode == MODE_R) || (cur_ff.addressing_mode == MODE_M)) begin
               ex_acc    = 1'b1;
               ex_target = (cur_ff.addressing_mode == MODE_R) ? va : mword;
               if ((cur_ff.action == ACT_JEQ) ? eq_ff : gt_ff) begin
                  ip_in = ex_target;
                  ex_jt = 1'b1;
               end
            end
         end
         ACT_CMP: begin
            if ((cur_ff.addressing_mode == MODE_RR) || (cur_ff.addressing_mode == MODE_RI)) begin
               ex_acc = 1'b1;
               ex_b   = (cur_ff.addressing_mode == MODE_RR) ? vb : cur_ff.second_operand;
               eq_in  = (va == ex_b);
               gt_in  = (va > ex_b);
            end
         end
         ACT_NOT: begin
            if (cur_ff.addressing_mode == MODE_R) begin
               ex_acc       = 1'b1;
               ex_reg_we    = 1'b1;
               ex_reg_wdata = reg_merge(cur_ff.first_operand, rda_ff, ~va);
            end else if (cur_ff.addressing_mode == MODE_M) begin
               ex_acc       = 1'b1;
               ex_mem_we    = 1'b1;
               ex_mem_wdata = ~mem_rd_ff;
            end
         end
         default: begin
            ex_acc = 1'b0;
         end
      endcase
   end

   // data memory port selection
   always_comb begin
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = cur_addr;
      mem_wdata = ex_mem_wdata;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_ff;
            mem_wdata = 8'h00;
         end
         ST_ISSUE: begin
            mem_re   = buf_valid_ff;
            mem_addr = (buf_ff.addressing_mode == MODE_RM) ?
                       buf_ff.second_operand[MEM_ADDR_BITS-1:0] :
                       buf_ff.first_operand[MEM_ADDR_BITS-1:0];
         end
         ST_FETCH2: begin
            mem_re   = 1'b1;
            mem_addr = cur_addr_next;
         end
         ST_EXEC: begin
            mem_we = exec_fire && ex_mem_we;
         end
         ST_WRITE2: begin
            mem_we    = 1'b1;
            mem_addr  = cur_addr_next;
            mem_wdata = wr2_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // register file write port selection
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         rf_we    = clr_cnt_ff < MEM_ADDR_BITS'(NUM_REGS);
         rf_waddr = clr_cnt_ff[RIDX_BITS-1:0];
         rf_wdata = 16'h0000;
      end else begin
         rf_we    = exec_fire && ex_reg_we && ina_ff;
         rf_waddr = cur_ff.first_operand[RIDX_BITS-1:0];
         rf_wdata = ex_reg_wdata;
      end
   end

   // single-port byte memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_mem[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         mem_rd_ff <= data_mem[mem_addr];
      end
   end

   // register file memory, two read ports and one write port
   always_ff @(posedge clock) begin
      if (rf_we) begin
         reg_mem[rf_waddr] <= rf_wdata;
      end
      if (take) begin
         rda_ff <= reg_mem[rd_addr_a];
         rdb_ff <= reg_mem[rd_addr_b];
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + MEM_ADDR_BITS'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (take) begin
               state_in = buf_word_rd ? ST_FETCH2 : ST_EXEC;
            end
         end
         ST_FETCH2: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ex_word_wr ? ST_WRITE2 : ST_ISSUE;
            end
         end
         ST_WRITE2: begin
            state_in = ST_ISSUE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // buffer and response occupancy
   always_comb begin
      buf_valid_in = buf_valid_ff;
      if (req_fire) begin
         buf_valid_in = 1'b1;
      end else if (take) begin
         buf_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ip_ff        <= 16'h0000;
         eq_ff        <= 1'b0;
         gt_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         buf_valid_ff <= buf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            ip_ff <= ip_in;
            eq_ff <= eq_in;
            gt_ff <= gt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff <= req_data;
      end
      if (take) begin
         cur_ff <= buf_ff;
         ina_ff <= buf_ina;
         inb_ff <= buf_inb;
      end
      if (state_ff == ST_FETCH2) begin
         byte_hi_ff <= mem_rd_ff;
      end
      if (exec_fire) begin
         wr2_ff <= ex_wr2;
         rsp_ff <= '{accepted: ex_acc, jump_taken: ex_jt, program_pointer: ip_in,
                     equal_flag: eq_in, greater_flag: gt_in};
      end
   end

endmodule
